// ----- design/hdht_pkg.sv -----
// shared types, constants and sha-256 round functions
`default_nettype none
package hdht_pkg;
    localparam logic [63:0] TARGET_RESET = 64'h0000_0000_FFFF_0000;
    localparam int NUM_ROUNDS = 64;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];
    typedef t_word t_sched [16];

    localparam t_word RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_state IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word bswap(input t_word x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // one compression round on the working state
    function automatic t_state round_fn(input t_state s, input t_word k, input t_word w);
        t_word t1;
        t_word t2;
        t_state r;
        t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + k + w;
        t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        r[7] = s[6]; r[6] = s[5]; r[5] = s[4]; r[4] = s[3] + t1;
        r[3] = s[2]; r[2] = s[1]; r[1] = s[0]; r[0] = t1 + t2;
        round_fn = r;
    endfunction

    // shift the 16-word message window by one
    function automatic t_sched sched_fn(input t_sched w);
        t_word s0;
        t_word s1;
        t_sched r;
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i + 1];
        end
        r[15] = w[0] + s0 + w[9] + s1;
        sched_fn = r;
    endfunction
endpackage
`default_nettype wire

// ----- design/header_double_hash_target_check_top.sv -----
// top level: three chained compressions and the target compare
// path from start to o_result_strobe: the three compressions, then compare registers r_v4 and o_result_strobe
// throughput: one header per cycle, busy is always low; 64 round stages per compress
// each stage holds one round; the result receiver cannot stall
// reset: synchronous active low, clears valid bits and loads the target with 0x00000000FFFF0000
`default_nettype none
module header_double_hash_target_check_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_header_version,
    input  wire logic [63:0] i_prev_hash_0,
    input  wire logic [63:0] i_prev_hash_1,
    input  wire logic [63:0] i_prev_hash_2,
    input  wire logic [63:0] i_prev_hash_3,
    input  wire logic [63:0] i_merkle_root_0,
    input  wire logic [63:0] i_merkle_root_1,
    input  wire logic [63:0] i_merkle_root_2,
    input  wire logic [63:0] i_merkle_root_3,
    input  wire logic [31:0] i_time_stamp,
    input  wire logic [31:0] i_difficulty_bits,
    input  wire logic [31:0] i_nonce_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_result_strobe,
    output logic             o_target_hit,
    output logic [31:0]      o_nonce_out,
    output logic [63:0]      o_hash_top
);
    import hdht_pkg::*;

    localparam int TAG1_W = 96 + 32;

    logic [63:0] r_target;

    // pipeline never stalls
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_valid) begin
            r_target <= i_cfg_data;
        end
    end

    // first block: header bytes 0..63 as big-endian words
    t_sched blk1;
    always_comb begin
        blk1[0]  = bswap(i_header_version);
        blk1[1]  = i_prev_hash_0[63:32];  blk1[2]  = i_prev_hash_0[31:0];
        blk1[3]  = i_prev_hash_1[63:32];  blk1[4]  = i_prev_hash_1[31:0];
        blk1[5]  = i_prev_hash_2[63:32];  blk1[6]  = i_prev_hash_2[31:0];
        blk1[7]  = i_prev_hash_3[63:32];  blk1[8]  = i_prev_hash_3[31:0];
        blk1[9]  = i_merkle_root_0[63:32]; blk1[10] = i_merkle_root_0[31:0];
        blk1[11] = i_merkle_root_1[63:32]; blk1[12] = i_merkle_root_1[31:0];
        blk1[13] = i_merkle_root_2[63:32]; blk1[14] = i_merkle_root_2[31:0];
        blk1[15] = i_merkle_root_3[63:32];
    end

    // tail words of the header travel alongside the first compress
    logic [TAG1_W-1:0] tag1_in;
    assign tag1_in = {i_merkle_root_3[31:0], bswap(i_time_stamp),
                      bswap(i_difficulty_bits), bswap(i_nonce_value)};

    logic              v1;
    t_state            h1;
    logic [TAG1_W-1:0] tag1;

    hdht_compress #(.TAG_W(TAG1_W)) u_c1 (
        .i_clk, .i_rst_n, .i_valid(start), .i_chain(IV), .i_block(blk1),
        .i_tag(tag1_in), .o_valid(v1), .o_chain(h1), .o_tag(tag1)
    );

    // second block: last 16 header bytes plus padding, length 640 bits
    t_sched blk2;
    always_comb begin
        blk2[0] = tag1[127:96];
        blk2[1] = tag1[95:64];
        blk2[2] = tag1[63:32];
        blk2[3] = tag1[31:0];
        blk2[4] = 32'h8000_0000;
        for (int i = 5; i < 15; i++) begin
            blk2[i] = '0;
        end
        blk2[15] = 32'd640;
    end

    logic   v2;
    t_state h2;
    logic [31:0] tag2;

    hdht_compress #(.TAG_W(32)) u_c2 (
        .i_clk, .i_rst_n, .i_valid(v1), .i_chain(h1), .i_block(blk2),
        .i_tag(tag1[31:0]), .o_valid(v2), .o_chain(h2), .o_tag(tag2)
    );

    // second hash over the 32-byte digest, length 256 bits
    t_sched blk3;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            blk3[i] = h2[i];
        end
        blk3[8] = 32'h8000_0000;
        for (int i = 9; i < 15; i++) begin
            blk3[i] = '0;
        end
        blk3[15] = 32'd256;
    end

    logic   v3;
    t_state h3;
    logic [31:0] tag3;

    hdht_compress #(.TAG_W(32)) u_c3 (
        .i_clk, .i_rst_n, .i_valid(v2), .i_chain(IV), .i_block(blk3),
        .i_tag(tag2), .o_valid(v3), .o_chain(h3), .o_tag(tag3)
    );

    // compare stage: digest byte 31 is most significant
    logic [63:0] top;
    logic        low_zero;
    assign top      = {bswap(h3[7]), bswap(h3[6])};
    assign low_zero = ({h3[0], h3[1], h3[2], h3[3], h3[4], h3[5]} == '0);

    logic        r_v4;
    logic [63:0] r_top;
    logic        r_lt;
    logic        r_eq;
    logic [31:0] r_nonce4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4            <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            r_v4            <= v3;
            o_result_strobe <= r_v4;
        end
        r_top    <= top;
        r_lt     <= top < r_target;
        r_eq     <= (top == r_target) && low_zero;
        r_nonce4 <= bswap(tag3);
        o_target_hit <= r_lt || r_eq;
        o_hash_top   <= r_top;
        o_nonce_out  <= r_nonce4;
    end
endmodule
`default_nettype wire

// ----- design/hdht_compress.sv -----
// fully unrolled sha-256 compression, one register stage per round
`default_nettype none
module hdht_compress #(
    parameter int TAG_W = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire hdht_pkg::t_state      i_chain,
    input  wire hdht_pkg::t_sched      i_block,
    input  wire logic [TAG_W-1:0]      i_tag,
    output logic                       o_valid,
    output hdht_pkg::t_state           o_chain,
    output logic [TAG_W-1:0]           o_tag
);
    import hdht_pkg::*;

    localparam int N = NUM_ROUNDS;

    logic             r_vld   [N+1];
    t_state           r_st    [N+1];
    t_state           r_chain [N+1];
    t_sched           r_w     [N+1];
    logic [TAG_W-1:0] r_tag   [N+1];

    always_comb begin
        r_vld[0]   = i_valid;
        r_st[0]    = i_chain;
        r_chain[0] = i_chain;
        r_w[0]     = i_block;
        r_tag[0]   = i_tag;
    end

    for (genvar g = 0; g < N; g++) begin : g_rnd
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_st[g+1]    <= round_fn(r_st[g], RK[g], r_w[g][0]);
            r_w[g+1]     <= sched_fn(r_w[g]);
            r_chain[g+1] <= r_chain[g];
            r_tag[g+1]   <= r_tag[g];
        end
    end

    // feed-forward add, registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[N];
        end
        for (int i = 0; i < 8; i++) begin
            o_chain[i] <= r_chain[N][i] + r_st[N][i];
        end
        o_tag <= r_tag[N];
    end
endmodule
`default_nettype wire
